>>> hdl/v3n_pkg.sv
// Shared types and defaults for the 3D vector normalizer.
`default_nettype none
package v3n_pkg;
  localparam int FieldWidth      = 32;
  localparam int InWidthDef      = 32;
  localparam int OutFracBitsDef  = 30;

  typedef struct packed {
    logic signed [FieldWidth-1:0] vec_x;
    logic signed [FieldWidth-1:0] vec_y;
    logic signed [FieldWidth-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] unit_x;
    logic signed [FieldWidth-1:0] unit_y;
    logic signed [FieldWidth-1:0] unit_z;
    logic                         was_zero;
  } vec_out_t;
endpackage
`default_nettype wire

>>> hdl/v3n_sqrt_cell.sv
// One root bit of the pipelined restoring integer square root.
`default_nettype none
module v3n_sqrt_cell #(
  parameter int W  = 32,
  parameter int PW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [2*W-1:0]   n_i,
  input  wire logic [W+1:0]     r_i,
  input  wire logic [W-1:0]     q_i,
  input  wire logic [PW-1:0]    pay_i,
  output logic                  valid_o,
  output logic [2*W-1:0]        n_o,
  output logic [W+1:0]          r_o,
  output logic [W-1:0]          q_o,
  output logic [PW-1:0]         pay_o
);
  logic [W+2:0] r_sh, trial, diff;
  logic         ge;
  logic [2*W-1:0] n_d;
  logic [W+1:0]   r_d;
  logic [W-1:0]   q_d;

  always_comb begin
    // partial remainder never exceeds twice the partial root, so its top bit is zero
    r_sh  = {r_i[W:0], n_i[2*W-1 -: 2]};
    trial = {1'b0, q_i, 2'b01};
    ge    = (r_sh >= trial);
    diff  = r_sh - trial;
    r_d   = ge ? diff[W+1:0] : r_sh[W+1:0];
    q_d   = {q_i[W-2:0], ge};
    n_d   = {n_i[2*W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= n_d;
      r_o   <= r_d;
      q_o   <= q_d;
      pay_o <= pay_i;
    end
  end
endmodule
`default_nettype wire

>>> hdl/v3n_div_cell.sv
// One quotient bit, three lanes, of the pipelined restoring divider.
`default_nettype none
module v3n_div_cell #(
  parameter int W     = 32,
  parameter int F     = 30,
  parameter bit SHIFT = 1'b1,
  parameter int PW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [W-1:0]      len_i,
  input  wire logic [2:0][W-1:0] rem_i,
  input  wire logic [2:0][F:0]   q_i,
  input  wire logic [PW-1:0]     pay_i,
  output logic                   valid_o,
  output logic [W-1:0]           len_o,
  output logic [2:0][W-1:0]      rem_o,
  output logic [2:0][F:0]        q_o,
  output logic [PW-1:0]          pay_o
);
  logic [2:0][W:0]   rem_s, diff;
  logic [2:0]        ge;
  logic [2:0][W-1:0] rem_d;
  logic [2:0][F:0]   q_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_s[l] = SHIFT ? {rem_i[l], 1'b0} : {1'b0, rem_i[l]};
      ge[l]    = (rem_s[l] >= {1'b0, len_i});
      diff[l]  = rem_s[l] - {1'b0, len_i};
      rem_d[l] = ge[l] ? diff[l][W-1:0] : rem_s[l][W-1:0];
      q_d[l]   = {q_i[l][F-1:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_o <= len_i;
      rem_o <= rem_d;
      q_o   <= q_d;
      pay_o <= pay_i;
    end
  end
endmodule
`default_nettype wire

>>> hdl/vector3_normalizer.sv
// Top level of the 3D vector normalizer.
`default_nettype none
// Normalizes a signed 3D vector to Q2.OUT_FRAC_BITS unit components, one
// transaction per clock while the output is not stalled. Stages: three
// registers for magnitude, squares and sum, one square-root cell per root
// bit, one divider cell per quotient bit (all three components share each
// cell), and the output register. The whole pipeline holds while a finished
// result is stalled at the output. A zero vector returns zeros with was_zero
// set.
module vector3_normalizer
  import v3n_pkg::*;
#(
  parameter int IN_WIDTH      = InWidthDef,
  parameter int OUT_FRAC_BITS = OutFracBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire vec_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output vec_out_t      out_data_o
);
  localparam int W   = IN_WIDTH;
  localparam int F   = OUT_FRAC_BITS;
  localparam int SPW = 3*W + 4;
  localparam int DPW = 4;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // magnitude, square and sum stages
  logic [2:0][W-1:0] raw, mag_d;
  logic [2:0]        neg_d;
  logic [2:0][W-1:0] mag_q, mag1_q, mag2_q;
  logic [2:0]        neg_q, neg1_q, neg2_q;
  logic [2:0][2*W-1:0] sq_q;
  logic [2*W-1:0]    sum_q;
  logic              v0_q, v1_q, v2_q;

  always_comb begin
    raw[0] = in_data_i.vec_x[W-1:0];
    raw[1] = in_data_i.vec_y[W-1:0];
    raw[2] = in_data_i.vec_z[W-1:0];
    for (int l = 0; l < 3; l++) begin
      neg_d[l] = raw[l][W-1];
      mag_d[l] = neg_d[l] ? (~raw[l] + W'(1)) : raw[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= (2*W)'(mag_q[l]) * (2*W)'(mag_q[l]);
      end
      mag1_q <= mag_q;
      neg1_q <= neg_q;
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
    end
  end

  // square root chain
  logic             sv   [W+1];
  logic [2*W-1:0]   sn   [W+1];
  logic [W+1:0]     sr   [W+1];
  logic [W-1:0]     sqv  [W+1];
  logic [SPW-1:0]   spay [W+1];

  assign sv[0]   = v2_q;
  assign sn[0]   = sum_q;
  assign sr[0]   = '0;
  assign sqv[0]  = '0;
  assign spay[0] = {mag2_q, neg2_q, (sum_q == '0)};

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    v3n_sqrt_cell #(.W(W), .PW(SPW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sv[k]), .n_i(sn[k]), .r_i(sr[k]), .q_i(sqv[k]), .pay_i(spay[k]),
      .valid_o(sv[k+1]), .n_o(sn[k+1]), .r_o(sr[k+1]), .q_o(sqv[k+1]),
      .pay_o(spay[k+1])
    );
  end

  // divider chain: first cell compares without shifting
  logic              dv   [F+2];
  logic [W-1:0]      dlen [F+2];
  logic [2:0][W-1:0] drem [F+2];
  logic [2:0][F:0]   dq   [F+2];
  logic [DPW-1:0]    dpay [F+2];

  assign dv[0]   = sv[W];
  assign dlen[0] = sqv[W];
  assign drem[0] = spay[W][SPW-1 -: 3*W];
  assign dq[0]   = '0;
  assign dpay[0] = spay[W][3:0];

  for (genvar k = 0; k <= F; k++) begin : g_div
    v3n_div_cell #(.W(W), .F(F), .SHIFT(k != 0), .PW(DPW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[k]), .len_i(dlen[k]), .rem_i(drem[k]), .q_i(dq[k]),
      .pay_i(dpay[k]),
      .valid_o(dv[k+1]), .len_o(dlen[k+1]), .rem_o(drem[k+1]), .q_o(dq[k+1]),
      .pay_o(dpay[k+1])
    );
  end

  // sign and zero handling into the output register
  logic [2:0][FieldWidth-1:0] mag_out, res;
  logic                       zero_f;
  vec_out_t                   out_d;

  always_comb begin
    zero_f = dpay[F+1][0];
    for (int l = 0; l < 3; l++) begin
      mag_out[l] = zero_f ? '0 : FieldWidth'(dq[F+1][l]);
      res[l]     = dpay[F+1][l+1] ? (FieldWidth'(0) - mag_out[l]) : mag_out[l];
    end
    out_d.unit_x   = res[0];
    out_d.unit_y   = res[1];
    out_d.unit_z   = res[2];
    out_d.was_zero = zero_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv[F+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= out_d;
    end
  end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the 3D vector normalizer.
`timescale 1ns / 1ps
module testbench;
  import v3n_pkg::*;

  localparam int Latency = 72;

  // Computes the unit vector of one input and checks results in order.
  class unit_vector_board;
    vec_out_t pending_q[$];
    int       errors = 0;

    static function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bit_v = 64'h4000_0000_0000_0000;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (n >= root + bit_v) begin
          n = n - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return root;
    endfunction

    function void note_vector(vec_in_t v);
      logic [31:0]     comp [3];
      longint unsigned mag [3];
      longint unsigned sum, len, q;
      logic [31:0]     unit [3];
      vec_out_t        res;
      comp[0] = v.vec_x;
      comp[1] = v.vec_y;
      comp[2] = v.vec_z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        // most negative value negates to itself; 33-bit form keeps it exact
        mag[i] = comp[i][31] ? 64'(33'h1_0000_0000 - {1'b0, comp[i]}) : 64'(comp[i]);
        sum = sum + mag[i] * mag[i];
      end
      res = '0;
      if (sum == 0) begin
        res.was_zero = 1'b1;
      end else begin
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          q = (mag[i] << OutFracBitsDef) / len;
          if (comp[i][31]) q = ~q + 1;
          unit[i] = q[31:0];
        end
        res.unit_x = unit[0];
        res.unit_y = unit[1];
        res.unit_z = unit[2];
      end
      pending_q.push_back(res);
    endfunction

    function void check_unit(vec_out_t got);
      vec_out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.unit_x !== want.unit_x)
        $display("%0t: unit_x expected %h actual %h", $time, want.unit_x, got.unit_x);
      if (got.unit_y !== want.unit_y)
        $display("%0t: unit_y expected %h actual %h", $time, want.unit_y, got.unit_y);
      if (got.unit_z !== want.unit_z)
        $display("%0t: unit_z expected %h actual %h", $time, want.unit_z, got.unit_z);
      if (got.was_zero !== want.was_zero)
        $display("%0t: was_zero expected %b actual %b", $time, want.was_zero, got.was_zero);
      if (got !== want) errors++;
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  vec_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  vec_out_t out_data_o;

  unit_vector_board board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;

  vector3_normalizer u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stall, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_unit(out_data_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_vector(vec_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_vector(v);
  endtask

  task automatic send_parts(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_in_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    send_vector(v);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(65535)) - 32768);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) send_parts(0, 0, 0);
      else send_parts(rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero, extremes, single axes, mixed signs
    send_parts(0, 0, 0);
    send_parts(32'h8000_0000, 0, 0);
    send_parts(0, 32'h8000_0000, 0);
    send_parts(0, 0, 32'h8000_0000);
    send_parts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_parts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_parts(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_parts(1, 0, 0);
    send_parts(32'hffff_ffff, 0, 0);
    send_parts(0, 1, 0);
    send_parts(0, 0, -1);
    send_parts(1, 1, 1);
    send_parts(-1, -1, -1);
    send_parts(3, 4, 0);
    send_parts(-3, 4, 12);
    send_parts(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_parts(32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001);
    send_parts(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fffe);
    send_parts(2, 32'h7fff_ffff, 1);
    send_parts(32'h8000_0001, 1, 32'h0001_0000);
    random_phase(400, 0, 0);
    random_phase(300, 85, 0);
    // sender pauses until everything is back
    drain();
    random_phase(300, 0, 85);
    random_phase(300, 23, 23);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(250, 0, 0);
    join
    random_phase(50, 0, 0);
    drain();
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
